@@ rtl/tssp_pkg.sv @@
// Shared types and constants for the text symbol packet parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tssp_pkg;

  // Header codes and length limits
  localparam logic [15:0] CODE_TEXT_A     = 16'd1;
  localparam logic [15:0] CODE_TEXT_B     = 16'd2;
  localparam logic [15:0] CODE_WITH_VALUE = 16'd8;
  localparam logic [15:0] MAX_LEN         = 16'd32767;
  localparam logic [16:0] FIXED_BYTES     = 17'd4;
  localparam logic [16:0] VALUE_BYTES     = 17'd2;
  localparam logic [2:0]  HDR_LAST_BYTE   = 3'd7;

  // Result kinds
  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VALUE,
    PH_TEXT,
    PH_DROP
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_CODE  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_TOO_FEW   = 3'd4
  } status_e;

  // One queue entry: everything one byte produces (a char, a summary or both)
  typedef struct packed {
    logic               has_char;
    logic [7:0]         text_char;
    logic [14:0]        char_index;
    logic               has_sum;
    status_e            status;
    logic [15:0]        hdr_code;
    logic [15:0]        block_length;
    logic signed [15:0] start_i;
    logic signed [15:0] start_j;
    logic [15:0]        text_value;
    logic               value_present;
  } cmd_t;

  // One result item as driven on the output ports
  typedef struct packed {
    logic               item_kind;
    logic [7:0]         text_char;
    logic [14:0]        char_index;
    logic [15:0]        hdr_code;
    logic [15:0]        block_length;
    logic signed [15:0] start_i;
    logic signed [15:0] start_j;
    logic [15:0]        text_value;
    logic               value_present;
    logic [2:0]         status;
    logic               last;
  } res_t;

endpackage

@@ rtl/tssp_front.sv @@
// Front end: accepts stream bytes, assembles header fields, classifies each byte.
// Depends on tssp_pkg; feeds tssp_queue with one cmd_t per byte that has results.
`timescale 1ns / 1ps

module tssp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                stream_end_i,
  input  logic                q_full_i,
  output logic                push_o,
  output tssp_pkg::cmd_t      cmd_o
);

  tssp_pkg::phase_e phase_q, phase_d, phase_pre;

  logic [2:0]         hcnt_q, hcnt_d;
  logic               vcnt_q, vcnt_d;
  logic [14:0]        idx_q, idx_d;
  logic [14:0]        rem_q, rem_d;
  logic [15:0]        code_q, code_d;
  logic [15:0]        len_q, len_d;
  logic signed [15:0] si_q, si_d;
  logic signed [15:0] sj_q, sj_d;
  logic [15:0]        val_q, val_d;

  logic        accept;
  logic        hdr_first, hdr_done, val_done, text_last, enter_text;
  logic        is8, code_ok, len_ok, open_pkt;
  logic [16:0] tl;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign hdr_first = (phase_q == tssp_pkg::PH_HEADER) && (hcnt_q == 3'd0);
  assign hdr_done  = (phase_q == tssp_pkg::PH_HEADER) && (hcnt_q == tssp_pkg::HDR_LAST_BYTE);
  assign val_done  = (phase_q == tssp_pkg::PH_VALUE) && vcnt_q;
  assign text_last = (phase_q == tssp_pkg::PH_TEXT) && (rem_q == 15'd1);

  // Field capture, big-endian shift into the field picked by the header byte count
  always_comb begin
    code_d = code_q;
    len_d  = len_q;
    si_d   = si_q;
    sj_d   = sj_q;
    val_d  = val_q;
    if (hdr_first) begin
      code_d = '0;
      len_d  = '0;
      si_d   = '0;
      sj_d   = '0;
      val_d  = '0;
    end
    if (phase_q == tssp_pkg::PH_HEADER) begin
      case (hcnt_q[2:1])
        2'd0:    code_d = {code_d[7:0], data_byte_i};
        2'd1:    len_d  = {len_d[7:0], data_byte_i};
        2'd2:    si_d   = {si_d[7:0], data_byte_i};
        default: sj_d   = {sj_d[7:0], data_byte_i};
      endcase
    end
    if (phase_q == tssp_pkg::PH_VALUE) begin
      val_d = {val_q[7:0], data_byte_i};
    end
  end

  assign is8     = (code_d == tssp_pkg::CODE_WITH_VALUE);
  assign code_ok = (code_d == tssp_pkg::CODE_TEXT_A) || (code_d == tssp_pkg::CODE_TEXT_B) || is8;
  assign len_ok  = (len_d != 16'd0) && (len_d <= tssp_pkg::MAX_LEN);
  // Text length; bit 16 set means the block is too short for its fixed fields
  assign tl      = {1'b0, len_d} - (val_done ? (tssp_pkg::FIXED_BYTES + tssp_pkg::VALUE_BYTES)
                                             : tssp_pkg::FIXED_BYTES);
  assign enter_text = (hdr_done && code_ok && len_ok && !is8) || val_done;

  // Counters
  always_comb begin
    hcnt_d = hcnt_q;
    vcnt_d = vcnt_q;
    idx_d  = idx_q;
    rem_d  = rem_q;
    if (phase_q == tssp_pkg::PH_HEADER) begin
      hcnt_d = hdr_done ? 3'd0 : hcnt_q + 3'd1;
      vcnt_d = 1'b0;
    end
    if (phase_q == tssp_pkg::PH_VALUE) begin
      vcnt_d = ~vcnt_q;
    end
    if (phase_q == tssp_pkg::PH_TEXT) begin
      idx_d = idx_q + 15'd1;
      rem_d = rem_q - 15'd1;
    end
    if (enter_text) begin
      idx_d = '0;
      rem_d = tl[14:0];
    end
    if (stream_end_i) begin
      hcnt_d = '0;
      vcnt_d = 1'b0;
      rem_d  = '0;
    end
  end

  // Next state
  always_comb begin
    phase_pre = phase_q;
    unique case (phase_q)
      tssp_pkg::PH_HEADER: begin
        if (hdr_done) begin
          if (!code_ok || !len_ok) begin
            phase_pre = tssp_pkg::PH_DROP;
          end else if (is8) begin
            phase_pre = tssp_pkg::PH_VALUE;
          end
        end
      end
      tssp_pkg::PH_VALUE:  phase_pre = tssp_pkg::PH_VALUE;
      tssp_pkg::PH_TEXT: begin
        if (text_last) begin
          phase_pre = tssp_pkg::PH_HEADER;
        end
      end
      tssp_pkg::PH_DROP:   phase_pre = tssp_pkg::PH_DROP;
      default:             phase_pre = tssp_pkg::PH_HEADER;
    endcase
    if (enter_text) begin
      if (tl[16]) begin
        phase_pre = tssp_pkg::PH_DROP;
      end else if (tl == 17'd0) begin
        phase_pre = tssp_pkg::PH_HEADER;
      end else begin
        phase_pre = tssp_pkg::PH_TEXT;
      end
    end
    phase_d = stream_end_i ? tssp_pkg::PH_HEADER : phase_pre;
  end

  // Packet left open by this byte: a stream end here means truncation
  assign open_pkt = (phase_pre == tssp_pkg::PH_VALUE) || (phase_pre == tssp_pkg::PH_TEXT) ||
                    ((phase_q == tssp_pkg::PH_HEADER) && !hdr_done);

  // Outputs: classify the byte into a queue entry
  always_comb begin
    cmd_o               = '0;
    cmd_o.has_char      = (phase_q == tssp_pkg::PH_TEXT);
    cmd_o.text_char     = data_byte_i;
    cmd_o.char_index    = idx_q;
    cmd_o.hdr_code      = code_d;
    cmd_o.block_length  = len_d;
    cmd_o.start_i       = si_d;
    cmd_o.start_j       = sj_d;
    cmd_o.value_present = is8;
    cmd_o.text_value    = is8 ? val_d : 16'd0;
    cmd_o.has_sum       = 1'b1;
    if (hdr_done && !code_ok) begin
      cmd_o.status = tssp_pkg::ST_BAD_CODE;
    end else if (hdr_done && !len_ok) begin
      cmd_o.status = tssp_pkg::ST_BAD_LEN;
    end else if (enter_text && tl[16]) begin
      cmd_o.status = tssp_pkg::ST_TOO_FEW;
    end else if ((enter_text && (tl == 17'd0)) || text_last) begin
      cmd_o.status = tssp_pkg::ST_OK;
    end else if (stream_end_i && open_pkt) begin
      cmd_o.status = tssp_pkg::ST_TRUNCATED;
    end else begin
      cmd_o.status  = tssp_pkg::ST_OK;
      cmd_o.has_sum = 1'b0;
    end
    push_o = accept && (cmd_o.has_char || cmd_o.has_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tssp_pkg::PH_HEADER;
      hcnt_q  <= '0;
      vcnt_q  <= 1'b0;
      idx_q   <= '0;
      rem_q   <= '0;
      code_q  <= '0;
      len_q   <= '0;
      si_q    <= '0;
      sj_q    <= '0;
      val_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      vcnt_q  <= vcnt_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      code_q  <= code_d;
      len_q   <= len_d;
      si_q    <= si_d;
      sj_q    <= sj_d;
      val_q   <= val_d;
    end
  end

endmodule

@@ rtl/tssp_queue.sv @@
// Small FIFO of classified byte entries between front and back end.
// Depends on tssp_pkg for the entry type.
`timescale 1ns / 1ps

module tssp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tssp_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output tssp_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tssp_pkg::cmd_t entries_q [DEPTH];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/tssp_back.sv @@
// Back end: expands queue entries into result transactions through an output register.
// Depends on tssp_pkg; reads the head of tssp_queue.
`timescale 1ns / 1ps

module tssp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tssp_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output tssp_pkg::res_t res_o
);

  tssp_pkg::res_t res_q, res_d, char_res, sum_res;
  logic           valid_q, valid_d;
  logic           half_q, half_d;   // char of the head entry already sent
  logic           load;

  always_comb begin
    char_res            = '0;
    char_res.item_kind  = tssp_pkg::KIND_TEXT;
    char_res.text_char  = head_i.text_char;
    char_res.char_index = head_i.char_index;

    sum_res               = '0;
    sum_res.item_kind     = tssp_pkg::KIND_SUMMARY;
    sum_res.hdr_code      = head_i.hdr_code;
    sum_res.block_length  = head_i.block_length;
    sum_res.start_i       = head_i.start_i;
    sum_res.start_j       = head_i.start_j;
    sum_res.text_value    = head_i.text_value;
    sum_res.value_present = head_i.value_present;
    sum_res.status        = head_i.status;
    sum_res.last          = 1'b1;
  end

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    res_d   = res_q;
    valid_d = valid_q;
    half_d  = half_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.has_char && !half_q) begin
          res_d  = char_res;
          half_d = head_i.has_sum;
          pop_o  = !head_i.has_sum;
        end else begin
          res_d  = sum_res;
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/text_symbol_packet_parser.sv @@
// Text symbol packet parser, top level. Depends on tssp_pkg, tssp_front, tssp_queue, tssp_back.
// Path: a result passes through the queue write and then the output register after its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; a byte that closes a text field yields two
// transactions, which the back end sends one after the other while the queue keeps taking bytes.
// Reset: rst_ni clears phase, counters, queue pointers and output valid at once;
// no clearing pass, the block takes bytes as soon as reset is released.
`timescale 1ns / 1ps

module text_symbol_packet_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte stream in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               stream_end_i,
  // Result items out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               item_kind_o,
  output logic [7:0]         text_char_o,
  output logic [14:0]        char_index_o,
  output logic [15:0]        hdr_code_o,
  output logic [15:0]        block_length_o,
  output logic signed [15:0] start_i_o,
  output logic signed [15:0] start_j_o,
  output logic [15:0]        text_value_o,
  output logic               value_present_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  // Front end -> queue: one entry per byte that produces anything
  tssp_pkg::cmd_t q_wdata, q_head;
  logic           q_push, q_pop, q_full, q_empty;
  tssp_pkg::res_t res;

  // Front: header assembly, code/length checks, text counting, drop-until-end
  tssp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .stream_end_i (stream_end_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .cmd_o        (q_wdata)
  );

  // Decoupling queue; stalls the byte stream only when full
  tssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: char then summary per entry, registered output
  tssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign item_kind_o     = res.item_kind;
  assign text_char_o     = res.text_char;
  assign char_index_o    = res.char_index;
  assign hdr_code_o      = res.hdr_code;
  assign block_length_o  = res.block_length;
  assign start_i_o       = res.start_i;
  assign start_j_o       = res.start_j;
  assign text_value_o    = res.text_value;
  assign value_present_o = res.value_present;
  assign status_o        = res.status;
  assign last_o          = res.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue write while full");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A value is only reported for value-carrying packets
  a_value_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == tssp_pkg::KIND_SUMMARY) && value_present_o)
      |-> (hdr_code_o == tssp_pkg::CODE_WITH_VALUE))
    else $error("value present on a packet without value");

  // Text transactions carry no summary content
  a_text_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == tssp_pkg::KIND_TEXT))
      |-> (!last_o && (status_o == tssp_pkg::ST_OK) && (hdr_code_o == 16'd0)))
    else $error("text transaction with summary fields");

endmodule
